FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the swept box collision test.
// No dependencies; the macros compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: design/sbc_pkg.sv
// Package of the swept box collision test: widths, side codes and the
// information that travels beside the divider. No dependencies.
package sbc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = COORD_W - 1;
  localparam int STEP_W    = FRAC_BITS + 1;
  // Doubled center and half slab distances.
  localparam int C2_W      = COORD_W + 2;
  localparam int HALF_W    = COORD_W + 2;
  // Velocity times step, and the direction taken from it.
  localparam int PROD_W    = COORD_W + STEP_W + 1;
  localparam int D_W       = PROD_W - FRAC_BITS;
  // Divider numerator, divisor and signed quotient.
  localparam int NMAG_W    = HALF_W + 1;
  localparam int NUM_W     = NMAG_W + FRAC_BITS;
  localparam int DEN_W     = D_W;
  localparam int Q_W       = NUM_W + 1;
  // Contact offset product and the sum that follows it.
  localparam int PC_W      = D_W + 1 + FRAC_BITS + 2;
  localparam int SUM_W     = PC_W - FRAC_BITS + 1;

  localparam int LANES    = 4;
  localparam int LANE_XLO = 0;
  localparam int LANE_XHI = 1;
  localparam int LANE_YLO = 2;
  localparam int LANE_YHI = 3;

  typedef enum logic [2:0] {
    SIDE_NONE  = 3'd0,
    SIDE_POS_X = 3'd1,
    SIDE_NEG_X = 3'd2,
    SIDE_POS_Y = 3'd3,
    SIDE_NEG_Y = 3'd4
  } side_t;

  typedef struct packed {
    logic signed [C2_W-1:0] c2x;
    logic signed [C2_W-1:0] c2y;
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic                   vzero;
    logic                   zx;
    logic                   zy;
    logic                   insx;
    logic                   insy;
    logic [LANES-1:0]       qneg;
  } side_info_t;

endpackage

FILE: design/sbc_prep.sv
// Front end of the swept box collision test: input register, slab distances,
// direction multiply and divider operand setup. Depends on sbc_pkg.
module sbc_prep (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic signed [sbc_pkg::COORD_W-1:0] mover_x,
  input  logic signed [sbc_pkg::COORD_W-1:0] mover_y,
  input  logic [sbc_pkg::SIZE_W-1:0]        mover_w,
  input  logic [sbc_pkg::SIZE_W-1:0]        mover_h,
  input  logic signed [sbc_pkg::COORD_W-1:0] vel_x,
  input  logic signed [sbc_pkg::COORD_W-1:0] vel_y,
  input  logic [sbc_pkg::STEP_W-1:0]        step_time,
  input  logic signed [sbc_pkg::COORD_W-1:0] block_x,
  input  logic signed [sbc_pkg::COORD_W-1:0] block_y,
  input  logic [sbc_pkg::SIZE_W-1:0]        block_w,
  input  logic [sbc_pkg::SIZE_W-1:0]        block_h,
  output logic                              out_vld,
  output logic [sbc_pkg::LANES-1:0][sbc_pkg::NUM_W-1:0] out_num,
  output logic [sbc_pkg::LANES-1:0][sbc_pkg::DEN_W-1:0] out_den,
  output sbc_pkg::side_info_t               out_info
);
  import sbc_pkg::*;

  // First stage: registered input item.
  logic                      a_vld_r;
  logic signed [COORD_W-1:0] mx_r, my_r, vx_r, vy_r, bx_r, by_r;
  logic [SIZE_W-1:0]         mw_r, mh_r, bw_r, bh_r;
  logic [STEP_W-1:0]         st_r;

  // Second stage: doubled centers, half slab distances, products.
  logic                      b_vld_r;
  logic signed [C2_W-1:0]    c2x_r, c2y_r, c2x_nxt, c2y_nxt;
  logic signed [HALF_W-1:0]  h_r [LANES];
  logic signed [HALF_W-1:0]  h_nxt [LANES];
  logic signed [PROD_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic                      vzero_r;

  // Third stage: divider operands.
  logic                      c_vld_r;
  logic [LANES-1:0][NUM_W-1:0] num_r, num_nxt;
  logic [LANES-1:0][DEN_W-1:0] den_r, den_nxt;
  side_info_t                info_r, info_nxt;

  logic signed [COORD_W:0]   mw_s, mh_s, bw_s, bh_s;
  logic signed [STEP_W:0]    st_s;

  assign mw_s = $signed({2'b00, mw_r});
  assign mh_s = $signed({2'b00, mh_r});
  assign bw_s = $signed({2'b00, bw_r});
  assign bh_s = $signed({2'b00, bh_r});
  assign st_s = $signed({1'b0, st_r});

  // Slab distances are kept halved: low edge minus center is 2*(bx - mx - mw),
  // high edge minus center is 2*(bx + bw - mx).
  always_comb begin
    c2x_nxt = (C2_W'(mx_r) <<< 1) + C2_W'(mw_s);
    c2y_nxt = (C2_W'(my_r) <<< 1) + C2_W'(mh_s);
    h_nxt[LANE_XLO] = HALF_W'(bx_r) - HALF_W'(mx_r) - HALF_W'(mw_s);
    h_nxt[LANE_XHI] = HALF_W'(bx_r) + HALF_W'(bw_s) - HALF_W'(mx_r);
    h_nxt[LANE_YLO] = HALF_W'(by_r) - HALF_W'(my_r) - HALF_W'(mh_s);
    h_nxt[LANE_YHI] = HALF_W'(by_r) + HALF_W'(bh_s) - HALF_W'(my_r);
    px_nxt = PROD_W'(vx_r) * PROD_W'(st_s);
    py_nxt = PROD_W'(vy_r) * PROD_W'(st_s);
  end

  // Direction is the product floored to the fraction; the divisor is
  // twice its magnitude and the quotient sign is handled afterward.
  always_comb begin
    logic signed [D_W-1:0] dx, dy, dl;
    logic [D_W-1:0]        dabs;
    logic [HALF_W-1:0]     habs;
    dx = $signed(px_r[PROD_W-1:FRAC_BITS]);
    dy = $signed(py_r[PROD_W-1:FRAC_BITS]);
    for (int l = 0; l < LANES; l++) begin
      dl   = (l < LANE_YLO) ? dx : dy;
      dabs = dl[D_W-1] ? (~dl + 1'b1) : dl;
      habs = h_r[l][HALF_W-1] ? (~h_r[l] + 1'b1) : h_r[l];
      den_nxt[l] = {dabs[DEN_W-2:0], 1'b0};
      num_nxt[l] = {habs, 1'b0, {FRAC_BITS{1'b0}}};
      info_nxt.qneg[l] = h_r[l][HALF_W-1] ^ dl[D_W-1];
    end
    info_nxt.c2x   = c2x_r;
    info_nxt.c2y   = c2y_r;
    info_nxt.dx    = dx;
    info_nxt.dy    = dy;
    info_nxt.vzero = vzero_r;
    info_nxt.zx    = (dx == '0);
    info_nxt.zy    = (dy == '0);
    info_nxt.insx  = h_r[LANE_XLO][HALF_W-1] && !h_r[LANE_XHI][HALF_W-1] &&
                     (h_r[LANE_XHI] != '0);
    info_nxt.insy  = h_r[LANE_YLO][HALF_W-1] && !h_r[LANE_YHI][HALF_W-1] &&
                     (h_r[LANE_YHI] != '0);
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r <= mover_x;
      my_r <= mover_y;
      mw_r <= mover_w;
      mh_r <= mover_h;
      vx_r <= vel_x;
      vy_r <= vel_y;
      st_r <= step_time;
      bx_r <= block_x;
      by_r <= block_y;
      bw_r <= block_w;
      bh_r <= block_h;
      c2x_r <= c2x_nxt;
      c2y_r <= c2y_nxt;
      for (int l = 0; l < LANES; l++) begin
        h_r[l] <= h_nxt[l];
      end
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      vzero_r <= (vx_r == '0) && (vy_r == '0);
      num_r   <= num_nxt;
      den_r   <= den_nxt;
      info_r  <= info_nxt;
    end
  end

  assign out_vld  = c_vld_r;
  assign out_num  = num_r;
  assign out_den  = den_r;
  assign out_info = info_r;

endmodule

FILE: design/sbc_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in
// lockstep with a side payload. Standalone; no package needed.
module sbc_div #(
  parameter int NW = 51,
  parameter int DW = 33,
  parameter int LN = 4,
  parameter int SW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic [LN-1:0][NW-1:0]  in_num,
  input  logic [LN-1:0][DW-1:0]  in_den,
  input  logic [SW-1:0]          in_side,
  output logic                   out_vld,
  output logic [LN-1:0][NW-1:0]  out_quo,
  output logic [SW-1:0]          out_side
);

  // Per stage: partial remainder, numerator shifting into quotient, divisor.
  logic [LN-1:0][DW-1:0] rem_r   [NW];
  logic [LN-1:0][NW-1:0] nq_r    [NW];
  logic [LN-1:0][DW-1:0] den_r   [NW];
  logic [SW-1:0]         side_r  [NW];
  logic [NW-1:0]         vld_r;
  logic [LN-1:0][DW-1:0] rem_nxt [NW];
  logic [LN-1:0][NW-1:0] nq_nxt  [NW];

  // One trial subtraction per stage and lane.
  always_comb begin
    logic [DW-1:0] rin, din;
    logic [NW-1:0] nin;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    for (int s = 0; s < NW; s++) begin
      for (int l = 0; l < LN; l++) begin
        if (s == 0) begin
          rin = '0;
          nin = in_num[l];
          din = in_den[l];
        end else begin
          rin = rem_r[s-1][l];
          nin = nq_r[s-1][l];
          din = den_r[s-1][l];
        end
        trial = {rin, nin[NW-1]};
        diff  = {1'b0, trial} - {2'b00, din};
        if (!diff[DW+1]) begin
          rem_nxt[s][l] = diff[DW-1:0];
          nq_nxt[s][l]  = {nin[NW-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = trial[DW-1:0];
          nq_nxt[s][l]  = {nin[NW-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NW-2:0], in_vld};
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NW; s++) begin
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
        if (s == 0) begin
          den_r[s]  <= in_den;
          side_r[s] <= in_side;
        end else begin
          den_r[s]  <= den_r[s-1];
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = nq_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

FILE: design/sbc_resolve.sv
// Back end of the swept box collision test: quotient signs, slab overlap,
// hit decision, contact point and the output register. Depends on sbc_pkg.
module sbc_resolve (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic [sbc_pkg::LANES-1:0][sbc_pkg::NUM_W-1:0] in_quo,
  input  sbc_pkg::side_info_t                 in_info,
  output logic                                out_vld,
  output logic                                out_hit,
  output logic signed [sbc_pkg::COORD_W-1:0]  out_hit_time,
  output logic signed [sbc_pkg::COORD_W-1:0]  out_contact_x,
  output logic signed [sbc_pkg::COORD_W-1:0]  out_contact_y,
  output sbc_pkg::side_t                      out_side
);
  import sbc_pkg::*;

  // Clamp a wide signed value to the coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_q(input logic signed [Q_W-1:0] v);
    logic all_one, all_zero;
    all_one  = &v[Q_W-1:COORD_W-1];
    all_zero = ~|v[Q_W-1:COORD_W-1];
    if (all_one || all_zero) begin
      return v[COORD_W-1:0];
    end else if (v[Q_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // Stage 1: signed slab times.
  logic                  v1_r;
  logic signed [Q_W-1:0] q1_r [LANES];
  side_info_t            i1_r;
  // Stage 2: near and far time per axis, early miss.
  logic                  v2_r, miss2_r;
  logic signed [Q_W-1:0] nx2_r, fx2_r, ny2_r, fy2_r;
  side_info_t            i2_r;
  // Stage 3: combined entry time, exit sign and side.
  logic                  v3_r, miss3_r, hfneg3_r;
  logic signed [Q_W-1:0] hn3_r;
  side_t                 side3_r;
  side_info_t            i3_r;
  // Stage 4: range test, saturated time, contact offsets.
  logic                  v4_r, miss4_r, inr4_r;
  logic signed [COORD_W-1:0] ht4_r;
  logic signed [PC_W-1:0]    pcx4_r, pcy4_r;
  logic signed [C2_W-1:0]    c2x4_r, c2y4_r;
  side_t                 side4_r;
  // Stage 5: output register.
  logic                  v5_r, hit5_r;
  logic signed [COORD_W-1:0] ht5_r, cx5_r, cy5_r;
  side_t                 side5_r;

  logic signed [Q_W-1:0] q1_nxt [LANES];
  logic signed [Q_W-1:0] nx2_nxt, fx2_nxt, ny2_nxt, fy2_nxt;
  logic                  miss2_nxt, miss3_nxt, hfneg3_nxt;
  logic signed [Q_W-1:0] hn3_nxt;
  side_t                 side3_nxt;
  logic signed [PC_W-1:0] pcx4_nxt, pcy4_nxt;
  logic                  inr4_nxt;
  logic                  hit5_nxt;
  logic signed [COORD_W-1:0] ht5_nxt, cx5_nxt, cy5_nxt;
  side_t                 side5_nxt;

  // Stage 1: apply the quotient sign.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q1_nxt[l] = in_info.qneg[l] ? -$signed({1'b0, in_quo[l]})
                                  : $signed({1'b0, in_quo[l]});
    end
  end

  // Stage 2: order each slab's times; zero-direction slabs need the center inside.
  always_comb begin
    nx2_nxt = (q1_r[LANE_XLO] < q1_r[LANE_XHI]) ? q1_r[LANE_XLO] : q1_r[LANE_XHI];
    fx2_nxt = (q1_r[LANE_XLO] < q1_r[LANE_XHI]) ? q1_r[LANE_XHI] : q1_r[LANE_XLO];
    ny2_nxt = (q1_r[LANE_YLO] < q1_r[LANE_YHI]) ? q1_r[LANE_YLO] : q1_r[LANE_YHI];
    fy2_nxt = (q1_r[LANE_YLO] < q1_r[LANE_YHI]) ? q1_r[LANE_YHI] : q1_r[LANE_YLO];
    miss2_nxt = i1_r.vzero || (i1_r.zx && !i1_r.insx) || (i1_r.zy && !i1_r.insy) ||
                (i1_r.zx && i1_r.zy);
  end

  // Stage 3: an unbounded axis defers to the other; otherwise intersect slabs.
  always_comb begin
    logic signed [Q_W-1:0] hf;
    side_t sx, sy;
    sx = i2_r.dx[D_W-1] ? SIDE_POS_X : SIDE_NEG_X;
    sy = i2_r.dy[D_W-1] ? SIDE_POS_Y : SIDE_NEG_Y;
    miss3_nxt = miss2_r;
    if (i2_r.zx) begin
      hn3_nxt   = ny2_r;
      hf        = fy2_r;
      side3_nxt = sy;
    end else if (i2_r.zy) begin
      hn3_nxt   = nx2_r;
      hf        = fx2_r;
      side3_nxt = sx;
    end else begin
      if ((nx2_r > fy2_r) || (ny2_r > fx2_r)) begin
        miss3_nxt = 1'b1;
      end
      hn3_nxt = (nx2_r > ny2_r) ? nx2_r : ny2_r;
      hf      = (fx2_r < fy2_r) ? fx2_r : fy2_r;
      if (nx2_r > ny2_r) begin
        side3_nxt = sx;
      end else if (nx2_r < ny2_r) begin
        side3_nxt = sy;
      end else begin
        side3_nxt = SIDE_NONE;
      end
    end
    hfneg3_nxt = hf[Q_W-1];
  end

  // Stage 4: entry within one step, and the offset 2*d*t for the contact point.
  always_comb begin
    logic signed [D_W:0]       dx2, dy2;
    logic signed [FRAC_BITS+1:0] hs;
    dx2 = $signed({i3_r.dx, 1'b0});
    dy2 = $signed({i3_r.dy, 1'b0});
    hs  = $signed({1'b0, hn3_r[FRAC_BITS:0]});
    inr4_nxt = !hn3_r[Q_W-1] && (hn3_r[Q_W-2:FRAC_BITS] == '0);
    pcx4_nxt = PC_W'(dx2) * PC_W'(hs);
    pcy4_nxt = PC_W'(dy2) * PC_W'(hs);
  end

  // Stage 5: contact center, and zeroed fields on a miss.
  always_comb begin
    logic signed [SUM_W-1:0] sx, sy;
    sx = SUM_W'(c2x4_r) + SUM_W'($signed(pcx4_r[PC_W-1:FRAC_BITS]));
    sy = SUM_W'(c2y4_r) + SUM_W'($signed(pcy4_r[PC_W-1:FRAC_BITS]));
    hit5_nxt  = 1'b0;
    ht5_nxt   = '0;
    cx5_nxt   = '0;
    cy5_nxt   = '0;
    side5_nxt = SIDE_NONE;
    if (!miss4_r) begin
      ht5_nxt = ht4_r;
      if (inr4_r) begin
        hit5_nxt  = 1'b1;
        cx5_nxt   = sat_q(Q_W'($signed(sx[SUM_W-1:1])));
        cy5_nxt   = sat_q(Q_W'($signed(sy[SUM_W-1:1])));
        side5_nxt = side4_r;
      end
    end
  end

  // Valid bits of the five stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        q1_r[l] <= q1_nxt[l];
      end
      i1_r     <= in_info;
      nx2_r    <= nx2_nxt;
      fx2_r    <= fx2_nxt;
      ny2_r    <= ny2_nxt;
      fy2_r    <= fy2_nxt;
      miss2_r  <= miss2_nxt;
      i2_r     <= i1_r;
      miss3_r  <= miss3_nxt;
      hfneg3_r <= hfneg3_nxt;
      hn3_r    <= hn3_nxt;
      side3_r  <= side3_nxt;
      i3_r     <= i2_r;
      miss4_r  <= miss3_r || hfneg3_r;
      inr4_r   <= inr4_nxt;
      ht4_r    <= sat_q(hn3_r);
      pcx4_r   <= pcx4_nxt;
      pcy4_r   <= pcy4_nxt;
      c2x4_r   <= i3_r.c2x;
      c2y4_r   <= i3_r.c2y;
      side4_r  <= side3_r;
      hit5_r   <= hit5_nxt;
      ht5_r    <= ht5_nxt;
      cx5_r    <= cx5_nxt;
      cy5_r    <= cy5_nxt;
      side5_r  <= side5_nxt;
    end
  end

  assign out_vld       = v5_r;
  assign out_hit       = hit5_r;
  assign out_hit_time  = ht5_r;
  assign out_contact_x = cx5_r;
  assign out_contact_y = cy5_r;
  assign out_side      = side5_r;

endmodule

FILE: design/swept_box_collision_test.sv
// Top level of the swept box collision test: front end, divider, back end.
// Depends on sbc_pkg, sbc_prep, sbc_div, sbc_resolve and assert_macros.svh.
//
// Usage: one test item enters on the in_ channel (valid/stall) and carries
// the moving box, its velocity, the time step and the fixed box. Positions
// and velocity are signed Q16.16, sizes unsigned Q15.16, step unsigned Q1.16.
// Exactly one result item leaves on the out_ channel for every item: hit
// flag, saturated entry time, contact center and hit side. The pipeline has
// 3 front-end stages, 51 divider stages (one quotient bit per stage, four
// slab divisions side by side) and 5 back-end stages; it takes one item per
// cycle unless a result is stalled. When the receiver stalls a valid result,
// the whole pipeline holds and in_stall rises in the same cycle; nothing is
// lost or repeated, and items behind the held result keep their places.
// Reset clears all valid bits; the block takes items the cycle after reset.
`include "assert_macros.svh"
module swept_box_collision_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sbc_pkg::COORD_W-1:0] in_mover_x,
  input  logic signed [sbc_pkg::COORD_W-1:0] in_mover_y,
  input  logic [sbc_pkg::SIZE_W-1:0]        in_mover_w,
  input  logic [sbc_pkg::SIZE_W-1:0]        in_mover_h,
  input  logic signed [sbc_pkg::COORD_W-1:0] in_vel_x,
  input  logic signed [sbc_pkg::COORD_W-1:0] in_vel_y,
  input  logic [sbc_pkg::STEP_W-1:0]        in_step_time,
  input  logic signed [sbc_pkg::COORD_W-1:0] in_block_x,
  input  logic signed [sbc_pkg::COORD_W-1:0] in_block_y,
  input  logic [sbc_pkg::SIZE_W-1:0]        in_block_w,
  input  logic [sbc_pkg::SIZE_W-1:0]        in_block_h,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic signed [sbc_pkg::COORD_W-1:0] out_hit_time,
  output logic signed [sbc_pkg::COORD_W-1:0] out_contact_x,
  output logic signed [sbc_pkg::COORD_W-1:0] out_contact_y,
  output logic [2:0]                        out_normal_side
);
  import sbc_pkg::*;

  localparam int INFO_W = $bits(side_info_t);

  logic                          adv;
  logic                          prep_vld, div_vld;
  logic [LANES-1:0][NUM_W-1:0]   prep_num, div_quo;
  logic [LANES-1:0][DEN_W-1:0]   prep_den;
  side_info_t                    prep_info;
  logic [INFO_W-1:0]             div_info;
  side_t                         res_side;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  sbc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_valid),
    .mover_x   (in_mover_x),
    .mover_y   (in_mover_y),
    .mover_w   (in_mover_w),
    .mover_h   (in_mover_h),
    .vel_x     (in_vel_x),
    .vel_y     (in_vel_y),
    .step_time (in_step_time),
    .block_x   (in_block_x),
    .block_y   (in_block_y),
    .block_w   (in_block_w),
    .block_h   (in_block_h),
    .out_vld   (prep_vld),
    .out_num   (prep_num),
    .out_den   (prep_den),
    .out_info  (prep_info)
  );

  sbc_div #(
    .NW (NUM_W),
    .DW (DEN_W),
    .LN (LANES),
    .SW (INFO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (prep_vld),
    .in_num   (prep_num),
    .in_den   (prep_den),
    .in_side  (prep_info),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_info)
  );

  sbc_resolve u_resolve (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_vld        (div_vld),
    .in_quo        (div_quo),
    .in_info       (side_info_t'(div_info)),
    .out_vld       (out_valid),
    .out_hit       (out_hit),
    .out_hit_time  (out_hit_time),
    .out_contact_x (out_contact_x),
    .out_contact_y (out_contact_y),
    .out_side      (res_side)
  );

  assign out_normal_side = res_side;

  // A result without a hit carries no contact point and no side.
  `ASSERT_CLK(a_miss_clean, clk, rst_n, out_valid && !out_hit |-> out_contact_x == '0 && out_contact_y == '0 && out_normal_side == SIDE_NONE)
  // A hit always enters within the step.
  `ASSERT_CLK(a_hit_in_step, clk, rst_n, out_valid && out_hit |-> !out_hit_time[COORD_W-2+1] && out_hit_time[COORD_W-2:FRAC_BITS] == '0)
  // A stalled result holds the pipeline in the same cycle.
  `ASSERT_NEVER(a_stall_hold, clk, rst_n, out_valid && out_stall && !in_stall)

endmodule
